// ----- design/idpa_pkg.sv -----
// shared constants and types for the id pool allocator
`default_nettype none
package idpa_pkg;

    localparam int POOL_DEPTH = 1024;
    localparam int WORD_BITS  = 64;
    localparam int MAP_WORDS  = (POOL_DEPTH + WORD_BITS - 1) / WORD_BITS;
    localparam int ID_W       = 10;
    localparam int SIZE_W     = 11;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WADDR_W    = $clog2(MAP_WORDS);
    localparam int LWORD_W    = SIZE_W - BIT_W;
    localparam int TDATA_W    = 16;
    localparam int STAT_W     = 2;

    localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(1024);
    localparam logic [SIZE_W-1:0] POOL_MAX   = SIZE_W'(POOL_DEPTH);

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FREE  = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        FUNC_ASSIGN  = 1'b0,
        FUNC_RECYCLE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RECYCLE
    } t_state;

    typedef struct packed {
        logic               en;
        logic               set;
        logic [WADDR_W-1:0] waddr;
        logic [BIT_W-1:0]   bidx;
    } t_map_wr;

endpackage
`default_nettype wire

// ----- design/id_pool_allocator.sv -----
// id pool allocator top level: request sequencer, map and word scan
// usage:
//   s_* channel takes one request: tuser is the function (0 assign, 1 recycle),
//   tdata holds the id to recycle (ignored for assign).
//   m_* channel returns one result per request: tdata is the id assigned or
//   the recycled id (zero on failure), tuser the status
//   (0 ok, 1 pool full, 2 id out of range, 3 id not assigned).
//   cfg channel writes pool_size; always ready, write only while idle.
// flow:
//   assign is accepted while idle, then the word scan checks one 64-bit
//   map word per cycle, stopping at the first word with a free id or at
//   the word holding the pool limit (16 words for 1024 ids); it waits on
//   that word while the output slot is full. recycle checks and updates the
//   id's map word. one request is in work at a time; s_tready is high only while the sequencer is idle.
// reset: all ids free, pool_size 1024, no result pending.
// stall: a finished result sits in the output register; a new request can be
//   taken meanwhile, but the next result waits until m_tready frees the slot.
`default_nettype none
module id_pool_allocator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [idpa_pkg::TDATA_W-1:0]    s_tdata,   // id
    input  wire logic                            s_tuser,   // func
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [idpa_pkg::TDATA_W-1:0]    m_tdata,   // out_id
    output logic      [idpa_pkg::STAT_W-1:0]     m_tuser,   // status
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [idpa_pkg::SIZE_W-1:0]     i_cfg_data
);

    idpa_pkg::t_state            r_state, n_state;
    logic [idpa_pkg::WADDR_W-1:0] r_word, n_word;
    logic [idpa_pkg::ID_W-1:0]    r_id, n_id;
    logic                         r_ovalid, n_ovalid;
    logic [idpa_pkg::ID_W-1:0]    r_oid, n_oid;
    idpa_pkg::t_status            r_ostat, n_ostat;
    logic [idpa_pkg::SIZE_W-1:0]  r_pool;

    logic [idpa_pkg::SIZE_W-1:0]    limit;
    logic [idpa_pkg::WADDR_W-1:0]   rd_addr;
    logic [idpa_pkg::WORD_BITS-1:0] rd_data;
    idpa_pkg::t_map_wr              map_wr;
    logic                           found;
    logic [idpa_pkg::BIT_W-1:0]     bidx;
    logic                           last;
    logic                           out_free;
    logic                           mark;

    assign limit = (r_pool > idpa_pkg::POOL_MAX) ? idpa_pkg::POOL_MAX : r_pool;
    assign rd_addr = (r_state == idpa_pkg::S_RECYCLE)
                     ? r_id[idpa_pkg::ID_W-1:idpa_pkg::BIT_W] : r_word;
    assign mark = rd_data[r_id[idpa_pkg::BIT_W-1:0]];
    assign out_free = !r_ovalid || m_tready;

    idpa_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr      (map_wr)
    );

    idpa_word_scan u_scan (
        .i_word  (rd_data),
        .i_widx  (r_word),
        .i_limit (limit),
        .o_found (found),
        .o_bidx  (bidx),
        .o_last  (last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= idpa_pkg::S_IDLE;
            r_word   <= '0;
            r_ovalid <= 1'b0;
            r_pool   <= idpa_pkg::POOL_RESET;
        end else begin
            r_state  <= n_state;
            r_word   <= n_word;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                r_pool <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_oid   <= n_oid;
        r_ostat <= n_ostat;
    end

    always_comb begin
        n_state  = r_state;
        n_word   = r_word;
        n_id     = r_id;
        n_ovalid = r_ovalid && !m_tready;
        n_oid    = r_oid;
        n_ostat  = r_ostat;
        map_wr   = '0;
        s_tready = 1'b0;
        unique case (r_state)
            idpa_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    n_id   = s_tdata[idpa_pkg::ID_W-1:0];
                    n_word = '0;
                    n_state = (s_tuser == idpa_pkg::FUNC_RECYCLE)
                              ? idpa_pkg::S_RECYCLE : idpa_pkg::S_SCAN;
                end
            end
            idpa_pkg::S_SCAN: begin
                if (found) begin
                    if (out_free) begin
                        map_wr.en    = 1'b1;
                        map_wr.set   = 1'b1;
                        map_wr.waddr = r_word;
                        map_wr.bidx  = bidx;
                        n_oid        = {r_word, bidx};
                        n_ostat      = idpa_pkg::STAT_OK;
                        n_ovalid     = 1'b1;
                        n_state      = idpa_pkg::S_IDLE;
                    end
                end else if (last) begin
                    if (out_free) begin
                        n_oid    = '0;
                        n_ostat  = idpa_pkg::STAT_FULL;
                        n_ovalid = 1'b1;
                        n_state  = idpa_pkg::S_IDLE;
                    end
                end else begin
                    n_word = r_word + idpa_pkg::WADDR_W'(1);
                end
            end
            idpa_pkg::S_RECYCLE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_state  = idpa_pkg::S_IDLE;
                    n_oid    = '0;
                    if (idpa_pkg::SIZE_W'(r_id) >= limit) begin
                        n_ostat = idpa_pkg::STAT_RANGE;
                    end else if (!mark) begin
                        n_ostat = idpa_pkg::STAT_FREE;
                    end else begin
                        map_wr.en    = 1'b1;
                        map_wr.set   = 1'b0;
                        map_wr.waddr = r_id[idpa_pkg::ID_W-1:idpa_pkg::BIT_W];
                        map_wr.bidx  = r_id[idpa_pkg::BIT_W-1:0];
                        n_oid        = r_id;
                        n_ostat      = idpa_pkg::STAT_OK;
                    end
                end
            end
            default: begin
                n_state = idpa_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid    = r_ovalid;
    assign m_tdata     = idpa_pkg::TDATA_W'(r_oid);
    assign m_tuser     = r_ostat;
    assign o_cfg_ready = 1'b1;

endmodule
`default_nettype wire

// ----- design/idpa_map.sv -----
// used-mark map: one word read port, one single-bit set or clear port
`default_nettype none
module idpa_map (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [idpa_pkg::WADDR_W-1:0]         i_rd_addr,
    output logic      [idpa_pkg::WORD_BITS-1:0]       o_rd_data,
    input  wire idpa_pkg::t_map_wr                    i_wr
);

    logic [idpa_pkg::WORD_BITS-1:0] r_words [idpa_pkg::MAP_WORDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < idpa_pkg::MAP_WORDS; w++) begin
                r_words[w] <= '0;
            end
        end else if (i_wr.en) begin
            r_words[i_wr.waddr][i_wr.bidx] <= i_wr.set;
        end
    end

    assign o_rd_data = r_words[i_rd_addr];

endmodule
`default_nettype wire

// ----- design/idpa_word_scan.sv -----
// finds the lowest free id inside one map word below the pool limit
`default_nettype none
module idpa_word_scan (
    input  wire logic [idpa_pkg::WORD_BITS-1:0] i_word,
    input  wire logic [idpa_pkg::WADDR_W-1:0]   i_widx,
    input  wire logic [idpa_pkg::SIZE_W-1:0]    i_limit,
    output logic                                o_found,
    output logic      [idpa_pkg::BIT_W-1:0]     o_bidx,
    output logic                                o_last
);

    logic [idpa_pkg::LWORD_W-1:0]   lim_word;
    logic [idpa_pkg::LWORD_W-1:0]   w_ext;
    logic [idpa_pkg::WORD_BITS-1:0] mask;
    logic [idpa_pkg::WORD_BITS-1:0] free_v;
    logic [idpa_pkg::WORD_BITS-1:0] low_v;

    always_comb begin
        lim_word = i_limit[idpa_pkg::SIZE_W-1:idpa_pkg::BIT_W];
        w_ext    = idpa_pkg::LWORD_W'(i_widx);
        if (lim_word > w_ext) begin
            mask = '1;
        end else if (lim_word == w_ext) begin
            mask = (idpa_pkg::WORD_BITS'(1) << i_limit[idpa_pkg::BIT_W-1:0])
                   - idpa_pkg::WORD_BITS'(1);
        end else begin
            mask = '0;
        end
        free_v  = ~i_word & mask;
        low_v   = free_v & (~free_v + idpa_pkg::WORD_BITS'(1));
        o_found = |free_v;
        o_bidx  = '0;
        for (int b = 0; b < idpa_pkg::WORD_BITS; b++) begin
            if (low_v[b]) begin
                o_bidx = o_bidx | idpa_pkg::BIT_W'(b);
            end
        end
        o_last = (i_widx == idpa_pkg::WADDR_W'(idpa_pkg::MAP_WORDS - 1))
                 || (lim_word <= w_ext);
    end

endmodule
`default_nettype wire

// ----- tb/tb_id_pool_allocator.sv -----
// self-checking testbench for the id pool allocator: directed, back-pressure and random requests
`timescale 1ns / 1ps
module tb_id_pool_allocator;
    import idpa_pkg::*;

    typedef struct packed {
        logic [TDATA_W-1:0] id;
        t_status            status;
    } t_id_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [STAT_W-1:0]   m_tuser;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [SIZE_W-1:0]   i_cfg_data = '0;

    id_pool_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow copy of the used marks and pool size
    bit                used_marks [POOL_DEPTH];
    logic [SIZE_W-1:0] pool_size_q = POOL_RESET;
    t_id_result        pending_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;
    int mismatches    = 0;
    int requests_sent = 0;
    int results_seen  = 0;
    int full_seen     = 0;
    int cfg_writes    = 0;

    function automatic int active_limit();
        return (pool_size_q > POOL_MAX) ? POOL_DEPTH : int'(pool_size_q);
    endfunction

    function automatic t_id_result predict_id_result(t_func f, logic [ID_W-1:0] id);
        int         lim;
        t_id_result res;
        lim = active_limit();
        res.id = '0;
        if (f == FUNC_ASSIGN) begin
            res.status = STAT_FULL;
            for (int n = 0; n < lim; n++) begin
                if (!used_marks[n]) begin
                    used_marks[n] = 1'b1;
                    res.id = TDATA_W'(n);
                    res.status = STAT_OK;
                    break;
                end
            end
        end else if (int'(id) >= lim) begin
            res.status = STAT_RANGE;
        end else if (!used_marks[id]) begin
            res.status = STAT_FREE;
        end else begin
            used_marks[id] = 1'b0;
            res.id = TDATA_W'(id);
            res.status = STAT_OK;
        end
        return res;
    endfunction

    // a marked id below the limit if there is one, else any id
    function automatic logic [ID_W-1:0] pick_used_id();
        int lim;
        int start;
        int n;
        lim = active_limit();
        if (lim > 0) begin
            start = $urandom_range(lim - 1);
            for (int k = 0; k < lim; k++) begin
                n = (start + k) % lim;
                if (used_marks[n]) return ID_W'(n);
            end
        end
        return ID_W'($urandom);
    endfunction

    task automatic send_request(t_func f, logic [ID_W-1:0] id);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= TDATA_W'(id);
        do @(posedge i_clk); while (!s_tready);
        pending_results.push_back(predict_id_result(f, id));
        requests_sent++;
    endtask

    task automatic wait_for_results();
        int guard;
        guard = 0;
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_results.size() != 0) begin
            $display("results still outstanding: %0d", pending_results.size());
            mismatches++;
        end
        repeat (24) @(posedge i_clk);
    endtask

    task automatic write_pool_size(logic [SIZE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        pool_size_q = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic resize_pool(logic [SIZE_W-1:0] value);
        wait_for_results();
        write_pool_size(value);
    endtask

    // receiver: long hold-off when asked, random stalls otherwise
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_id_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser == STAT_FULL) full_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: id %0d status %0d", m_tdata, m_tuser);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.id || m_tuser !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected id %0d status %0d, got id %0d status %0d",
                                 want.id, want.status, m_tdata, m_tuser);
                end
            end
        end
    end

    task automatic test_reset_state();
        send_request(FUNC_ASSIGN, '1);
        send_request(FUNC_ASSIGN, '0);
        send_request(FUNC_ASSIGN, ID_W'(555));
        send_request(FUNC_RECYCLE, ID_W'(1));
        send_request(FUNC_RECYCLE, ID_W'(1));
        send_request(FUNC_ASSIGN, '0);
        send_request(FUNC_RECYCLE, ID_W'(1023));
    endtask

    task automatic test_pool_size_edges();
        // empty pool
        resize_pool(SIZE_W'(0));
        send_request(FUNC_ASSIGN, '0);
        send_request(FUNC_RECYCLE, ID_W'(0));
        // single id, already taken
        resize_pool(SIZE_W'(1));
        send_request(FUNC_ASSIGN, '0);
        send_request(FUNC_RECYCLE, ID_W'(0));
        send_request(FUNC_ASSIGN, '0);
        // marks above a lowered limit stay put
        send_request(FUNC_RECYCLE, ID_W'(2));
        // size above depth saturates
        resize_pool(SIZE_W'(2047));
        send_request(FUNC_RECYCLE, ID_W'(2));
        send_request(FUNC_ASSIGN, '0);
        send_request(FUNC_RECYCLE, ID_W'(1023));
    endtask

    task automatic test_output_backpressure();
        resize_pool(SIZE_W'(64));
        @(negedge i_clk);
        hold_cycles <= 300;
        for (int i = 0; i < 80; i++)
            send_request(FUNC_ASSIGN, ID_W'($urandom));
        // pause until everything is back, then release a few
        wait_for_results();
        for (int i = 0; i < 8; i++)
            send_request(FUNC_RECYCLE, pick_used_id());
    endtask

    task automatic run_random_batch(int count, int assign_pct);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < assign_pct)
                send_request(FUNC_ASSIGN, ID_W'($urandom));
            else if (r < assign_pct + (100 - assign_pct) * 3 / 4)
                send_request(FUNC_RECYCLE, pick_used_id());
            else
                send_request(FUNC_RECYCLE, ID_W'($urandom));
        end
    endtask

    function automatic logic [SIZE_W-1:0] random_pool_size();
        int r;
        r = $urandom_range(99);
        if (r < 70) return SIZE_W'($urandom_range(130, 1));
        if (r < 80) return SIZE_W'(0);
        if (r < 90) return SIZE_W'($urandom_range(2047, 1024));
        return SIZE_W'($urandom_range(2047));
    endfunction

    task automatic test_random_traffic(int sender_pct, int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int b = 0; b < 5; b++) begin
            resize_pool(random_pool_size());
            run_random_batch(50, $urandom_range(75, 45));
        end
    endtask

    task automatic test_deep_scan();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        resize_pool(SIZE_W'(1024));
        run_random_batch(200, 85);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        send_idle_pct = 20;
        recv_idle_pct = 54;
        test_reset_state();
        test_pool_size_edges();
        test_output_backpressure();
        test_random_traffic(20, 54);
        test_random_traffic(54, 20);
        test_deep_scan();
        wait_for_results();

        $display("covered %0d requests, %0d results (%0d pool full), %0d pool size writes",
                 requests_sent, results_seen, full_seen, cfg_writes);
        $display("pool sizes from empty to saturated, long output stall, three idle mixes");
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d failures", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
design/idpa_pkg.sv
design/idpa_map.sv
design/idpa_word_scan.sv
design/id_pool_allocator.sv
tb/tb_id_pool_allocator.sv
